/* rtl/core/mco_pkg.sv */
package mco_pkg;

    // Default collider bounds handed to the top level parameters.
    localparam int MAX_WIDTH_DEF  = 32;
    localparam int MAX_HEIGHT_DEF = 32;

    // Control that travels with each row word into the shared row unit.
    typedef struct packed {
        logic pend;    // a row word pair is in the read registers
        logic fill_a;  // collider A is a solid box, use all ones for its row
        logic fill_b;  // collider B is a solid box, use all ones for its row
    } row_ctrl_t;

endpackage

/* rtl/core/mask_collider_overlap_test.sv */
// Overlap test between two rectangular colliders A and B on a cell grid.
// Sizes and the simple (solid box) flags are written through the cfg_* port;
// the user must write them only while the block is idle, which the block
// itself does not enforce. Complex colliders use mask rows loaded with
// action 0 words. A load is accepted when start is high and busy is low and
// completes in that cycle, so busy never rises for it. A query (action 1)
// raises busy and produces exactly one result word: done pulses high for a
// single cycle with overlapping valid alongside it, and the receiver must
// take it then because it cannot stall the block. When the bounding boxes
// miss, or both colliders are solid, the box state decides the result and
// done is registered from it. Otherwise the shared rows (at most MAX_HEIGHT)
// are scanned one row per cycle, set by the single read port of each mask
// memory; the scan stops early on the first occupied shared cell.
// busy falls in the cycle that done shows, so the next word can be started
// right then. Mask rows never written hold no defined contents and must not
// be covered by a complex collider.
module mask_collider_overlap_test #(
    parameter int MAX_WIDTH  = mco_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = mco_pkg::MAX_HEIGHT_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    // Command channel
    input  logic               start,
    output logic               busy,
    input  logic               action,
    input  logic               collider_sel,
    input  logic [4:0]         row_index,
    input  logic [31:0]        row_bits,
    input  logic signed [15:0] pos_a_x,
    input  logic signed [15:0] pos_a_y,
    input  logic signed [15:0] pos_b_x,
    input  logic signed [15:0] pos_b_y,
    // Result channel
    output logic               done,
    output logic               overlapping,
    // Configuration port
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [5:0]         cfg_data
);

    // Size counters are wide enough to hold the bound itself; memory row
    // addresses are only as wide as the depth needs.
    localparam int SWW = $clog2(MAX_WIDTH + 1);
    localparam int SWH = $clog2(MAX_HEIGHT + 1);
    localparam int AW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    // Positions plus a size of up to 64 cells fit in 18 signed bits.
    localparam int EXT_W = 18;

    // Configuration register indexes.
    localparam logic [2:0] REG_WIDTH_A  = 3'd0;
    localparam logic [2:0] REG_HEIGHT_A = 3'd1;
    localparam logic [2:0] REG_SIMPLE_A = 3'd2;
    localparam logic [2:0] REG_WIDTH_B  = 3'd3;
    localparam logic [2:0] REG_HEIGHT_B = 3'd4;
    localparam logic [2:0] REG_SIMPLE_B = 3'd5;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic SEL_B    = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_BOX  = 3'b010,
        S_SCAN = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic [5:0] width_a_reg, height_a_reg, width_b_reg, height_b_reg;
    logic       simple_a_reg, simple_b_reg;

    logic signed [15:0] ax_reg, ay_reg, bx_reg, by_reg;

    logic [SWH-1:0] ya_reg, ya_next, yb_reg, yb_next;
    logic           pend_reg, pend_next;
    logic           done_reg, done_next;
    logic           ovl_reg, ovl_next;

    logic [MAX_WIDTH-1:0] lowmask_a_reg, lowmask_b_reg;
    logic [SWW-1:0]       shamt_a_reg, shamt_b_reg;

    logic accept;
    logic wr_row_ok;
    logic issue;
    logic row_hit;

    logic [SWW-1:0] wa, wb;
    logic [SWH-1:0] ha, hb;

    logic signed [EXT_W-1:0] ax_e, ay_e, bx_e, by_e;
    logic signed [EXT_W-1:0] wa_e, ha_e, wb_e, hb_e;
    logic signed [EXT_W-1:0] dx, dy;
    logic                    box_hit;

    logic [MAX_WIDTH-1:0] row_a, row_b;
    mco_pkg::row_ctrl_t   row_ctrl;

    assign accept = start && !busy;
    assign busy   = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign overlapping = ovl_reg;

    // Configuration registers. Unknown indexes are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_a_reg  <= '0;
            height_a_reg <= '0;
            simple_a_reg <= 1'b1;
            width_b_reg  <= '0;
            height_b_reg <= '0;
            simple_b_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_WIDTH_A:  width_a_reg  <= cfg_data;
                REG_HEIGHT_A: height_a_reg <= cfg_data;
                REG_SIMPLE_A: simple_a_reg <= cfg_data[0];
                REG_WIDTH_B:  width_b_reg  <= cfg_data;
                REG_HEIGHT_B: height_b_reg <= cfg_data;
                REG_SIMPLE_B: simple_b_reg <= cfg_data[0];
                default:      ;
            endcase
        end
    end

    // Sizes above the bounds saturate to them.
    always_comb
    begin
        wa = (int'(width_a_reg)  > MAX_WIDTH)  ? SWW'(MAX_WIDTH)  : SWW'(width_a_reg);
        wb = (int'(width_b_reg)  > MAX_WIDTH)  ? SWW'(MAX_WIDTH)  : SWW'(width_b_reg);
        ha = (int'(height_a_reg) > MAX_HEIGHT) ? SWH'(MAX_HEIGHT) : SWH'(height_a_reg);
        hb = (int'(height_b_reg) > MAX_HEIGHT) ? SWH'(MAX_HEIGHT) : SWH'(height_b_reg);
    end

    // Box test in widened signed arithmetic so no sum can wrap.
    always_comb
    begin
        ax_e = EXT_W'(ax_reg);
        ay_e = EXT_W'(ay_reg);
        bx_e = EXT_W'(bx_reg);
        by_e = EXT_W'(by_reg);
        wa_e = EXT_W'(wa);
        ha_e = EXT_W'(ha);
        wb_e = EXT_W'(wb);
        hb_e = EXT_W'(hb);
        dx   = bx_e - ax_e;
        dy   = by_e - ay_e;
        box_hit = (ax_e < bx_e + wb_e) && (ax_e + wa_e > bx_e) &&
                  (ay_e < by_e + hb_e) && (ay_e + ha_e > by_e);
    end

    // Query positions are captured when the query is accepted.
    always_ff @(posedge clk)
    begin
        if (accept && (action != ACT_LOAD))
        begin
            ax_reg <= pos_a_x;
            ay_reg <= pos_a_y;
            bx_reg <= pos_b_x;
            by_reg <= pos_b_y;
        end
    end

    // Per-query column masks and relative shifts. When the boxes overlap,
    // the offset between the two left columns is below the width of the
    // collider further left, so the truncation to a shift amount is exact.
    // That collider is shifted right onto the column origin of the other.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_BOX)
        begin
            lowmask_a_reg <= ~({MAX_WIDTH{1'b1}} << wa);
            lowmask_b_reg <= ~({MAX_WIDTH{1'b1}} << wb);
            shamt_a_reg   <= (dx > 0) ? SWW'(dx) : '0;
            shamt_b_reg   <= (dx < 0) ? SWW'(ax_e - bx_e) : '0;
        end
    end

    // Sequencer: box test, then one row pair issued per cycle, with the
    // row unit judging the pair read in the cycle before.
    assign issue = (ya_reg < ha) && (yb_reg < hb);

    always_comb
    begin
        state_next = state_reg;
        ya_next    = ya_reg;
        yb_next    = yb_reg;
        pend_next  = 1'b0;
        done_next  = 1'b0;
        ovl_next   = ovl_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && (action != ACT_LOAD))
                begin
                    state_next = S_BOX;
                end
            end
            S_BOX:
            begin
                if (!box_hit || (simple_a_reg && simple_b_reg))
                begin
                    done_next  = 1'b1;
                    ovl_next   = box_hit;
                    state_next = S_IDLE;
                end
                else
                begin
                    // The first shared row sits at the offset of the lower
                    // collider's top inside the higher one.
                    ya_next    = (dy > 0) ? SWH'(dy) : '0;
                    yb_next    = (dy < 0) ? SWH'(ay_e - by_e) : '0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (row_hit)
                begin
                    done_next  = 1'b1;
                    ovl_next   = 1'b1;
                    state_next = S_IDLE;
                end
                else if (!issue && !pend_reg)
                begin
                    done_next  = 1'b1;
                    ovl_next   = 1'b0;
                    state_next = S_IDLE;
                end
                else
                begin
                    pend_next = issue;
                    if (issue)
                    begin
                        ya_next = ya_reg + SWH'(1);
                        yb_next = yb_reg + SWH'(1);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ya_reg    <= '0;
            yb_reg    <= '0;
            pend_reg  <= 1'b0;
            done_reg  <= 1'b0;
            ovl_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ya_reg    <= ya_next;
            yb_reg    <= yb_next;
            pend_reg  <= pend_next;
            done_reg  <= done_next;
            ovl_reg   <= ovl_next;
        end
    end

    // Loads to rows beyond the memory depth are dropped.
    assign wr_row_ok = int'(row_index) < MAX_HEIGHT;

    mco_mask_mem #(
        .WIDTH (MAX_WIDTH),
        .DEPTH (MAX_HEIGHT)
    ) u_mask_a (
        .clk     (clk),
        .wr_en   (accept && (action == ACT_LOAD) && (collider_sel != SEL_B) && wr_row_ok),
        .wr_addr (AW'(row_index)),
        .wr_data (MAX_WIDTH'(row_bits)),
        .rd_en   ((state_reg == S_SCAN) && issue),
        .rd_addr (ya_reg[AW-1:0]),
        .rd_data (row_a)
    );

    mco_mask_mem #(
        .WIDTH (MAX_WIDTH),
        .DEPTH (MAX_HEIGHT)
    ) u_mask_b (
        .clk     (clk),
        .wr_en   (accept && (action == ACT_LOAD) && (collider_sel == SEL_B) && wr_row_ok),
        .wr_addr (AW'(row_index)),
        .wr_data (MAX_WIDTH'(row_bits)),
        .rd_en   ((state_reg == S_SCAN) && issue),
        .rd_addr (yb_reg[AW-1:0]),
        .rd_data (row_b)
    );

    // A solid collider stands in as a full row, so mixed and complex pairs
    // share the same row test.
    always_comb
    begin
        row_ctrl.pend   = pend_reg && (state_reg == S_SCAN);
        row_ctrl.fill_a = simple_a_reg;
        row_ctrl.fill_b = simple_b_reg;
    end

    mco_row_unit #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_row_unit (
        .ctrl      (row_ctrl),
        .row_a     (row_a),
        .row_b     (row_b),
        .lowmask_a (lowmask_a_reg),
        .lowmask_b (lowmask_b_reg),
        .shamt_a   (shamt_a_reg),
        .shamt_b   (shamt_b_reg),
        .hit       (row_hit)
    );

endmodule

/* rtl/core/mco_mask_mem.sv */
module mco_mask_mem #(
    parameter int WIDTH = mco_pkg::MAX_WIDTH_DEF,
    parameter int DEPTH = mco_pkg::MAX_HEIGHT_DEF
) (
    input  logic                                      clk,
    input  logic                                      wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                          wr_data,
    input  logic                                      rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                          rd_data
);

    logic [WIDTH-1:0] rows_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            rows_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= rows_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/core/mco_row_unit.sv */
module mco_row_unit #(
    parameter int MAX_WIDTH = mco_pkg::MAX_WIDTH_DEF
) (
    input  mco_pkg::row_ctrl_t                   ctrl,
    input  logic [MAX_WIDTH-1:0]                 row_a,
    input  logic [MAX_WIDTH-1:0]                 row_b,
    input  logic [MAX_WIDTH-1:0]                 lowmask_a,
    input  logic [MAX_WIDTH-1:0]                 lowmask_b,
    input  logic [$clog2(MAX_WIDTH + 1)-1:0]     shamt_a,
    input  logic [$clog2(MAX_WIDTH + 1)-1:0]     shamt_b,
    output logic                                 hit
);

    logic [MAX_WIDTH-1:0] cut_a;
    logic [MAX_WIDTH-1:0] cut_b;
    logic [MAX_WIDTH-1:0] aligned_a;
    logic [MAX_WIDTH-1:0] aligned_b;

    // A solid box contributes a full row; both rows are trimmed to the
    // collider width and brought onto a common column origin.
    always_comb
    begin
        cut_a     = (ctrl.fill_a ? {MAX_WIDTH{1'b1}} : row_a) & lowmask_a;
        cut_b     = (ctrl.fill_b ? {MAX_WIDTH{1'b1}} : row_b) & lowmask_b;
        aligned_a = cut_a >> shamt_a;
        aligned_b = cut_b >> shamt_b;
        hit       = ctrl.pend & (|(aligned_a & aligned_b));
    end

endmodule

/* rtl/core/mco_checker.sv */
module mco_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic action,
    input logic done
);

    // A result word only appears as the block goes idle.
    assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("result word shown while busy");

    // The block only leaves a query by delivering its result word.
    assert property (@(posedge clk) disable iff (!rst_n) $fell(busy) |-> done)
        else $error("query ended without a result word");

    // An accepted query occupies the block in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && action) |=> busy)
        else $error("query accepted but block not busy");

    // A row load never produces a result word.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && !action) |=> !done)
        else $error("result word after a row load");

    // A result word lasts exactly one cycle.
    assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("result strobe longer than one cycle");

endmodule

bind mask_collider_overlap_test mco_checker u_mco_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .action (action),
    .done   (done)
);
